@@ hw/rtl/wpm_pkg.sv @@
// Shared constants, types and helpers for the wildcard pattern matcher.
`timescale 1ns / 1ps

package wpm_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int PAT_W       = 8 * MAX_PATTERN;
  localparam int POS_W       = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 6;
  localparam int REG_IDX_W   = 3;

  localparam logic [7:0]       WILDCARD = 8'h3F;
  localparam logic [POS_W-1:0] POS_MAX  = '1;

  // Register indexes; each register occupies eight bytes of address space.
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_CHARS0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_CHARS1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_CHARS2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_CHARS3 = 3'd4;

  // Configuration handed from the register block to the datapath.
  typedef struct packed {
    logic [LEN_W-1:0] pattern_length;
    logic [PAT_W-1:0] pattern;
  } wpm_cfg_t;

  // What each window cell needs to shift and compare.
  typedef struct packed {
    logic       shift;
    logic [7:0] pat;
    logic       care;
  } cell_ctrl_t;

  // Pattern character at a given index, character 0 in the low byte.
  function automatic logic [7:0] pat_at(input logic [PAT_W-1:0] pattern,
                                        input logic [IDX_W-1:0] idx);
    pat_at = pattern[8*idx +: 8];
  endfunction

endpackage

@@ hw/rtl/wpm_if.sv @@
// Stream interfaces for the text input and the match output.
`timescale 1ns / 1ps

interface wpm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       text_last;

  modport source (output valid, output text_char, output text_last, input ready);
  modport sink   (input valid, input text_char, input text_last, output ready);
endinterface

interface wpm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] match_start;

  modport source (output valid, output match_start, input ready);
  modport sink   (input valid, input match_start, output ready);
endinterface

@@ hw/rtl/wpm_cell.sv @@
// One window cell: holds a text byte, passes it on and compares it to its pattern byte.
`timescale 1ns / 1ps

module wpm_cell import wpm_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] din,
  output logic [7:0] dout,
  output logic       eq
);

  logic [7:0] char_r;
  logic [7:0] char_nxt;

  // Take the neighbor's byte whenever a new text beat enters the window.
  always_comb begin
    char_nxt = ctrl.shift ? din : char_r;
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  assign dout = char_r;

  // Cells beyond the pattern length and wildcard positions always agree.
  assign eq = !ctrl.care || (ctrl.pat == WILDCARD) || (ctrl.pat == char_r);

endmodule

@@ hw/rtl/wpm_cfg.sv @@
// APB register block holding the pattern length and pattern characters.
`timescale 1ns / 1ps

module wpm_cfg import wpm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output wpm_cfg_t              cfg
);

  logic [LEN_W-1:0]      len_r;
  logic [LEN_W-1:0]      len_nxt;
  logic [PAT_W-1:0]      pat_r;
  logic [PAT_W-1:0]      pat_nxt;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;

  // Register writes; addresses past the last register are ignored.
  always_comb begin
    len_nxt = len_r;
    pat_nxt = pat_r;
    if (wr_en) begin
      case (reg_idx)
        REG_PATTERN_LENGTH: len_nxt = pwdata[LEN_W-1:0];
        REG_PATTERN_CHARS0: pat_nxt[0*CFG_DATA_W +: CFG_DATA_W] = pwdata;
        REG_PATTERN_CHARS1: pat_nxt[1*CFG_DATA_W +: CFG_DATA_W] = pwdata;
        REG_PATTERN_CHARS2: pat_nxt[2*CFG_DATA_W +: CFG_DATA_W] = pwdata;
        REG_PATTERN_CHARS3: pat_nxt[3*CFG_DATA_W +: CFG_DATA_W] = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_W'(1);
      pat_r <= '0;
    end else begin
      len_r <= len_nxt;
      pat_r <= pat_nxt;
    end
  end

  // Read back.
  always_comb begin
    case (reg_idx)
      REG_PATTERN_LENGTH: prdata = CFG_DATA_W'(len_r);
      REG_PATTERN_CHARS0: prdata = pat_r[0*CFG_DATA_W +: CFG_DATA_W];
      REG_PATTERN_CHARS1: prdata = pat_r[1*CFG_DATA_W +: CFG_DATA_W];
      REG_PATTERN_CHARS2: prdata = pat_r[2*CFG_DATA_W +: CFG_DATA_W];
      REG_PATTERN_CHARS3: prdata = pat_r[3*CFG_DATA_W +: CFG_DATA_W];
      default:            prdata = '0;
    endcase
  end

  assign cfg.pattern_length = len_r;
  assign cfg.pattern        = pat_r;

endmodule

@@ hw/rtl/wildcard_pattern_matcher.sv @@
// Top level of the wildcard pattern matcher: window cell chain, match stage and registers.
`timescale 1ns / 1ps

// Usage:
// Text bytes arrive on in_bus, one per beat, with text_last marking the final
// byte of a text. Each beat whose window matches the pattern yields one beat
// on out_bus carrying the zero-based index where that match starts; beats
// that do not complete a match produce nothing. A pattern byte of 0x3F matches
// any text byte. Pattern length and characters are written over the APB port
// (eight-byte register stride) while no text is in flight.
// Throughput is one text byte per cycle while out_bus does not stall: the byte
// shifts into a chain of 32 window cells on acceptance, and all cells compare
// in parallel. The compare result of the window stage is then registered in
// the output register once that register is free.
// When out_bus stalls, the output register holds its beat and one more byte
// can sit in the window stage; after that in_bus.ready drops.
// Reset empties the pipeline, restarts the text position at zero and sets
// the pattern length to one with all pattern bytes zero. The position
// counter saturates at its maximum value within a long text.
module wildcard_pattern_matcher import wpm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  wpm_in_if.sink                in_bus,
  wpm_out_if.source             out_bus,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  wpm_cfg_t          cfg;
  logic [LEN_W-1:0]  len_eff;
  logic [POS_W-1:0]  len_m1;
  logic              accept_in;
  logic              out_free;
  logic              s1_adv;
  logic              hit;

  logic              s1_valid_r, s1_valid_nxt;
  logic [POS_W-1:0]  s1_pos_r, s1_pos_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  out_start_r, out_start_nxt;

  logic [7:0]             chain [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] eq;

  // Configuration registers.
  wpm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign cfg_pready = 1'b1;

  // Lengths above the window size are clamped.
  assign len_eff = (cfg.pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                             : cfg.pattern_length;
  assign len_m1  = POS_W'(len_eff) - POS_W'(1);

  // Handshake: the window stage moves on when the output register is free.
  assign out_free  = !out_valid_r || out_bus.ready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_bus.ready = !s1_valid_r || out_free;
  assign accept_in = in_bus.valid && in_bus.ready;

  // Window cell chain; cell j holds the byte j places back from the newest.
  assign chain[0] = in_bus.text_char;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    cell_ctrl_t       ctrl;
    logic [IDX_W-1:0] pidx;

    // Cell j lines up with pattern character len-1-j.
    assign pidx       = IDX_W'(len_eff - LEN_W'(j) - LEN_W'(1));
    assign ctrl.shift = accept_in;
    assign ctrl.care  = LEN_W'(j) < len_eff;
    assign ctrl.pat   = pat_at(cfg.pattern, pidx);

    wpm_cell u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .din  (chain[j]),
      .dout (chain[j+1]),
      .eq   (eq[j])
    );
  end

  // A match needs every cell to agree and enough bytes in the current text.
  assign hit = (&eq) && (len_eff != '0) && (s1_pos_r >= len_m1);

  // Text position and window stage bookkeeping.
  always_comb begin
    pos_nxt      = pos_r;
    s1_pos_nxt   = s1_pos_r;
    s1_valid_nxt = s1_valid_r;
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (accept_in) begin
      s1_valid_nxt = 1'b1;
      s1_pos_nxt   = pos_r;
      if (in_bus.text_last) begin
        pos_nxt = '0;
      end else if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_start_nxt = out_start_r;
    if (out_free) begin
      out_valid_nxt = s1_valid_r && hit;
      out_start_nxt = s1_pos_r - len_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_pos_r    <= s1_pos_nxt;
    out_start_r <= out_start_nxt;
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.match_start = out_start_r;

endmodule

@@ hw/rtl/wpm_checker.sv @@
// Port-level checks for the wildcard pattern matcher, bound to the top level.
`timescale 1ns / 1ps

module wpm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_match_start
);

  // Reset empties the output register.
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output beat present after reset.");

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_match_start))
    else $error("Result beat changed while stalled.");

  // The input only backs off while a result beat is waiting.
  a_ready_low_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("Input stalled without a waiting result.");

  // A fresh result beat follows an earlier accepted text beat.
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("Result beat without a matching text beat.");

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_bus.valid),
  .in_ready        (in_bus.ready),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .out_match_start (out_bus.match_start)
);

@@ dv/wpm_match_checker.sv @@
// Checker for the wildcard pattern matcher: predicts match starts and compares them.
`timescale 1ns / 1ps

module wpm_match_checker import wpm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  wpm_in_if                     in_bus,
  wpm_out_if                    out_bus,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [CFG_DATA_W-1:0] cfg_prdata,
  input  logic                  cfg_pready,
  input  logic                  all_sent,
  output int                    fail_count,
  output int                    starts_pending,
  output int                    starts_seen
);

  // Shadow copy of the registers and of the text state.
  logic [5:0]       len_reg;
  logic [63:0]      pat_words [4];
  logic [7:0]       window [MAX_PATTERN];
  logic [POS_W-1:0] next_pos;
  logic [POS_W-1:0] starts_due [$];
  bit               flushed;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    if (fail_count < 40) begin
      $display("%0t ns mismatch: %s got %h expected %h", $time, what, got, want);
    end
    fail_count++;
  endtask

  function automatic logic [63:0] reg_value(input logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_PATTERN_LENGTH: reg_value = {58'd0, len_reg};
      REG_PATTERN_CHARS0: reg_value = pat_words[0];
      REG_PATTERN_CHARS1: reg_value = pat_words[1];
      REG_PATTERN_CHARS2: reg_value = pat_words[2];
      REG_PATTERN_CHARS3: reg_value = pat_words[3];
      default:            reg_value = '0;
    endcase
  endfunction

  // Shift one text byte into the window and queue the start index if the
  // window now ends in a full pattern match.
  task automatic take_text_byte(input logic [7:0] c, input logic last);
    int               eff;
    int               k;
    bit               hit;
    logic [7:0]       p;
    logic [POS_W-1:0] pos;
    pos = next_pos;
    eff = (len_reg > MAX_PATTERN) ? MAX_PATTERN : int'(len_reg);
    for (k = MAX_PATTERN - 1; k > 0; k--) begin
      window[k] = window[k-1];
    end
    window[0] = c;
    // Bytes left over from an earlier text must never take part.
    hit = (eff > 0) && (pos >= POS_W'(eff - 1));
    for (k = 0; k < eff && hit; k++) begin
      p = pat_words[k >> 3][8*(k % 8) +: 8];
      if (p != WILDCARD && p != window[eff-1-k]) begin
        hit = 1'b0;
      end
    end
    if (last) begin
      next_pos = '0;
    end else if (next_pos != POS_MAX) begin
      next_pos = next_pos + 1'b1;
    end
    if (hit) begin
      starts_due = {starts_due, pos - POS_W'(eff - 1)};
    end
  endtask

  always @(posedge clk) begin
    logic [REG_IDX_W-1:0] idx;
    logic [POS_W-1:0]     want;
    idx = cfg_paddr[CFG_ADDR_W-1:3];
    if (!rst_n) begin
      len_reg    = 6'd1;
      pat_words  = '{default: '0};
      window     = '{default: '0};
      next_pos   = '0;
      starts_due.delete();
      fail_count  = 0;
      starts_seen = 0;
      flushed     = 1'b0;
    end else begin
      // Register writes update the shadow copy; reads are checked against it.
      if (cfg_psel && cfg_penable && cfg_pready && idx <= REG_PATTERN_CHARS3) begin
        if (cfg_pwrite) begin
          if (idx == REG_PATTERN_LENGTH) begin
            len_reg = cfg_pwdata[5:0];
          end else begin
            pat_words[2'(idx - REG_PATTERN_CHARS0)] = cfg_pwdata;
          end
        end else if (cfg_prdata !== reg_value(idx)) begin
          report($sformatf("register %0d readback", idx), cfg_prdata, reg_value(idx));
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        take_text_byte(in_bus.text_char, in_bus.text_last);
      end
      // Each output beat must match the oldest pending start index.
      if (out_bus.valid && out_bus.ready) begin
        starts_seen++;
        if (starts_due.size() == 0) begin
          report("unexpected match_start", 64'(out_bus.match_start), '0);
        end else begin
          want = starts_due.pop_front();
          if (out_bus.match_start !== want) begin
            report("match_start", 64'(out_bus.match_start), 64'(want));
          end
        end
      end
      if (all_sent && !flushed) begin
        while (starts_due.size() != 0) begin
          report("missing match_start", '0, 64'(starts_due.pop_front()));
        end
        flushed = 1'b1;
      end
    end
    starts_pending = starts_due.size();
  end

endmodule

@@ dv/wildcard_pattern_matcher_tb.sv @@
// Testbench top for the wildcard pattern matcher: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module wildcard_pattern_matcher_tb;
  import wpm_pkg::*;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  logic                  all_sent = 1'b0;
  int                    fail_count;
  int                    starts_pending;
  int                    starts_seen;

  // Stimulus bookkeeping.
  bit                    calm = 1'b0;
  int                    bytes_sent = 0;
  int                    settings_used = 0;
  logic [PAT_W-1:0]      pattern_bits;
  int                    pattern_eff;

  wpm_in_if  in_bus ();
  wpm_out_if out_bus ();

  wildcard_pattern_matcher dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  wpm_match_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_bus         (in_bus),
    .out_bus        (out_bus),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .all_sent       (all_sent),
    .fail_count     (fail_count),
    .starts_pending (starts_pending),
    .starts_seen    (starts_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Wait before the next beat on either side; calm stretches have none.
  function automatic int draw_wait();
    if (calm) begin
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Result side: stall a random number of cycles before each beat.
  initial begin
    int n;
    out_bus.ready = 1'b0;
    @(posedge clk);
    forever begin
      n = draw_wait();
      if (n > 0) begin
        out_bus.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  // All tasks below are entered and left at a rising clock edge.
  task automatic send_text_byte(input logic [7:0] c, input logic last);
    int n;
    if ($urandom_range(0, 47) == 0) begin
      calm = !calm;
    end
    n = draw_wait();
    if (n > 0) begin
      in_bus.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.text_char <= c;
    in_bus.text_last <= last;
    do @(posedge clk); while (!in_bus.ready);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_reg(input logic [REG_IDX_W-1:0] idx);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 3'b000};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending and let every pending match start and any non-matching
  // byte still in the pipeline drain out before touching registers.
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (starts_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_pattern(input logic [5:0] len, input logic [PAT_W-1:0] bits);
    int i;
    pattern_bits = bits;
    pattern_eff  = (len > MAX_PATTERN) ? MAX_PATTERN : int'(len);
    write_reg(REG_PATTERN_LENGTH, {58'd0, len});
    write_reg(REG_PATTERN_CHARS0, bits[63:0]);
    write_reg(REG_PATTERN_CHARS1, bits[127:64]);
    write_reg(REG_PATTERN_CHARS2, bits[191:128]);
    write_reg(REG_PATTERN_CHARS3, bits[255:192]);
    for (i = 0; i <= 4; i++) begin
      read_reg(REG_IDX_W'(i));
    end
    settings_used++;
  endtask

  // Text bytes lean toward the pattern alphabet so matches stay common.
  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(0, 7))
      0:       return "a";
      1:       return "b";
      2:       return WILDCARD;
      3:       return 8'h00;
      4:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_pattern_byte();
    case ($urandom_range(0, 5))
      0, 1:    return WILDCARD;
      2:       return "a";
      3:       return "b";
      4:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // One copy of the pattern, wildcards filled with random bytes; a stray
  // last flag now and then breaks the copy.
  task automatic send_pattern_copy();
    int         k;
    logic [7:0] c;
    for (k = 0; k < pattern_eff; k++) begin
      c = pattern_bits[8*k +: 8];
      if (c == WILDCARD && $urandom_range(0, 3) != 0) begin
        c = 8'($urandom);
      end
      if (k == pattern_eff - 1) begin
        send_text_byte(c, $urandom_range(0, 7) == 0);
      end else begin
        send_text_byte(c, $urandom_range(0, 59) == 0);
      end
    end
  endtask

  task automatic send_text_run(input int count);
    int target;
    int n;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      if (pattern_eff > 0 && $urandom_range(0, 9) < 6) begin
        send_pattern_copy();
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_text_byte(pick_text_byte(), $urandom_range(0, 39) == 0);
      end
    end
  endtask

  initial begin
    int               ph;
    int               k;
    logic [5:0]       len;
    logic [PAT_W-1:0] bits;
    in_bus.valid     = 1'b0;
    in_bus.text_char = '0;
    in_bus.text_last = 1'b0;
    pattern_bits     = '0;
    pattern_eff      = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a one-byte pattern of 0x00.
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte(8'h00, 1'b1);
    drain();

    // "a?c": short text ends before a match, so the window must not
    // carry bytes across the text boundary.
    bits = '1;
    bits[23:0] = {8'h63, WILDCARD, 8'h61};
    bits[191:128] = '0;
    load_pattern(6'd3, bits);
    send_text_byte("a", 1'b0);
    send_text_byte("b", 1'b1);
    send_text_byte("c", 1'b0);
    send_text_byte("a", 1'b0);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte("c", 1'b0);
    send_text_byte("a", 1'b0);
    send_text_byte(WILDCARD, 1'b0);
    send_text_byte("c", 1'b1);
    drain();

    // Zero length never matches.
    load_pattern(6'd0, '0);
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'h00, 1'b1);
    drain();

    // Only wildcards: a match at every index with enough bytes.
    load_pattern(6'd4, {(PAT_W/8){WILDCARD}});
    for (k = 0; k < 6; k++) begin
      send_text_byte(8'($urandom), k == 5);
    end
    drain();

    // Random phases, each under its own pattern setting.
    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       len = 6'd32;
        1:       len = 6'd63;
        2:       len = 6'd0;
        3:       len = 6'd1;
        4:       len = 6'($urandom_range(33, 62));
        default: len = 6'($urandom_range(2, 12));
      endcase
      for (k = 0; k < MAX_PATTERN; k++) begin
        bits[8*k +: 8] = pick_pattern_byte();
      end
      if (ph == 5) begin
        bits = {(PAT_W/8){WILDCARD}};
      end else if (ph == 6) begin
        for (k = 0; k < PAT_W / 32; k++) begin
          bits[32*k +: 32] = $urandom;
        end
      end
      load_pattern(len, bits);
      send_text_run(130);
      drain();
    end

    all_sent <= 1'b1;
    repeat (3) @(posedge clk);
    $display("Covered %0d text bytes under %0d pattern settings (lengths 0, 1, 32 and above).",
             bytes_sent, settings_used + 1);
    $display("Compared %0d match starts.", starts_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
